FILE: sv/esp_pkg.sv
// ----------------------------------------------------------------------------
// esp_pkg: shared types and constants of the EMA spike and plateau detector
// Register indexes, marker kinds, fixed-point constants, the sequencer state
// type and the request/response structs of the shared iterative divider.
// ----------------------------------------------------------------------------
package esp_pkg;

    // Configuration port
    localparam int unsigned CFG_IDX_W = 8;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_EMA_WINDOW       = 8'd0;
    localparam cfg_idx_t CFG_EXPLOSION_FACTOR = 8'd1;
    localparam cfg_idx_t CFG_SPIKE_FACTOR     = 8'd2;
    localparam cfg_idx_t CFG_PLATEAU_STEPS    = 8'd3;

    // Register reset values
    localparam logic [16:0] GAIN_RESET     = 17'd6242;  // gain for a window of 20
    localparam logic [15:0] EXPLOSION_RST  = 16'd1280;  // 5.0 in Q8.8
    localparam logic [15:0] SPIKE_RST      = 16'd768;   // 3.0 in Q8.8
    localparam logic [15:0] PLATEAU_RST    = 16'd100;

    // Marker kinds
    localparam logic [1:0] KIND_GRAD    = 2'd0;
    localparam logic [1:0] KIND_LOSS    = 2'd1;
    localparam logic [1:0] KIND_PLATEAU = 2'd2;

    // Fixed-point constants
    localparam logic [31:0] AVG_FLOOR      = 32'd655;    // 0.01 in Q16.16
    localparam logic [32:0] IMPROVE_MARGIN = 33'd7;      // 1e-4 in Q16.16
    localparam logic [16:0] SEV_ONE        = 17'd65536;  // 1.0 in Q1.16
    localparam logic [16:0] SEV_HALF       = 17'd32768;  // 0.5 in Q1.16
    localparam logic [16:0] STALL_MAX      = 17'd65536;
    localparam logic [17:0] GAIN_NUM_BASE  = 18'd131072; // 2.0 in Q2.16

    // Shared divider
    localparam int unsigned DIV_W     = 32;
    localparam int unsigned QUOT_W    = 18;
    localparam int unsigned DIV_CNT_W = 5;
    localparam logic [DIV_CNT_W-1:0] SEV_STEPS  = 5'd16;
    localparam logic [DIV_CNT_W-1:0] GAIN_STEPS = 5'd18;

    typedef struct packed {
        logic                 start;
        logic [DIV_W-1:0]     divisor;
        logic [DIV_W-1:0]     rem_init;   // starting remainder, below the divisor
        logic [QUOT_W-1:0]    num;        // dividend bits shifted in, MSB first
        logic [DIV_CNT_W-1:0] steps;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
    } div_rsp_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GAIN,
        ST_MUL_LOSS,
        ST_UPD_LOSS,
        ST_MUL_GRAD,
        ST_UPD_GRAD,
        ST_MUL_TG,
        ST_THR_G,
        ST_SEV_G,
        ST_DIV_G,
        ST_MUL_TL,
        ST_THR_L,
        ST_SEV_L,
        ST_DIV_L,
        ST_STALL,
        ST_OUT
    } state_t;

endpackage

FILE: sv/esp_div.sv
// ----------------------------------------------------------------------------
// esp_div: shared iterative restoring divider
// One quotient bit per cycle. The remainder starts below the divisor and
// takes one dividend bit per step, so a 33-bit compare and subtract is the
// only arithmetic in the loop.
// ----------------------------------------------------------------------------
module esp_div (
    input  logic             clk,
    input  logic             rst_n,
    input  esp_pkg::div_req_t req,
    output esp_pkg::div_rsp_t rsp
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [esp_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [esp_pkg::DIV_W-1:0]     rem_reg, rem_next;
    logic [esp_pkg::DIV_W-1:0]     dvs_reg, dvs_next;
    logic [esp_pkg::QUOT_W-1:0]    num_reg, num_next;
    logic [esp_pkg::QUOT_W-1:0]    quot_reg, quot_next;

    logic [esp_pkg::DIV_W:0]       trial;
    logic [esp_pkg::DIV_W:0]       trial_sub;
    logic                          fits;

    // Shift in the next dividend bit and try the subtraction
    always_comb
    begin
        trial     = {rem_reg, num_reg[esp_pkg::QUOT_W-1]};
        fits      = trial >= {1'b0, dvs_reg};
        trial_sub = trial - {1'b0, dvs_reg};
    end

    // Step control and datapath
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        num_next  = num_reg;
        quot_next = quot_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = req.steps;
            rem_next  = req.rem_init;
            dvs_next  = req.divisor;
            num_next  = req.num;
            quot_next = '0;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? trial_sub[esp_pkg::DIV_W-1:0] : trial[esp_pkg::DIV_W-1:0];
            num_next  = {num_reg[esp_pkg::QUOT_W-2:0], 1'b0};
            quot_next = {quot_reg[esp_pkg::QUOT_W-2:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == esp_pkg::DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        num_reg  <= num_next;
        quot_reg <= quot_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

    // A new request only arrives while the unit is free
    assert property (@(posedge clk) disable iff (!rst_n) req.start |-> !busy_reg)
        else $error("esp_div: request while busy");

    // The remainder stays below the divisor throughout a division
    assert property (@(posedge clk) disable iff (!rst_n) busy_reg |-> rem_reg < dvs_reg)
        else $error("esp_div: remainder not below divisor");

    // The last step raises done and frees the unit
    assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !req.start && cnt_reg == esp_pkg::DIV_CNT_W'(1)) |=> (done_reg && !busy_reg))
        else $error("esp_div: last step did not finish");

endmodule

FILE: sv/ema_spike_plateau_detector.sv
// ----------------------------------------------------------------------------
// ema_spike_plateau_detector: training metric anomaly detector
// Tracks moving averages of loss and gradient norm and raises gradient
// explosion, loss spike and loss plateau markers.
// ----------------------------------------------------------------------------
// One sample at a time goes through a small sequencer that reuses a single
// 17x32 multiplier and a single bit-serial divider. A sample passes the
// average, threshold, severity and stall states in turn; each spike marker
// that needs a severity division adds a divider run (one quotient bit per
// cycle), and each marker then waits in the output state for as long as the
// consumer holds off. The first sample after reset only seeds the averages
// and the best loss, and the block stays idle for the next one. Writing the
// window register recomputes the gain on the same divider, during which no
// sample or further write is taken. Markers of one sample come out in the
// order explosion, spike, plateau, with marker_last on the final one.
// ----------------------------------------------------------------------------
module ema_spike_plateau_detector (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] step_number,
    input  logic [31:0] loss_value,
    input  logic [31:0] grad_value,
    input  logic [63:0] time_stamp,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] marker_step,
    output logic [1:0]  marker_kind,
    output logic [16:0] marker_severity,
    output logic [31:0] marker_value,
    output logic [31:0] marker_threshold,
    output logic [63:0] marker_time,
    output logic        marker_last
);

    esp_pkg::state_t   state_reg, state_next;

    // Configuration
    logic [16:0] gain_reg, gain_next;
    logic [15:0] expl_reg, expl_next;
    logic [15:0] spike_reg, spike_next;
    logic [15:0] plat_reg, plat_next;

    // Detector state
    logic        first_reg, first_next;
    logic [31:0] la_reg, la_next;
    logic [31:0] ga_reg, ga_next;
    logic [31:0] best_reg, best_next;
    logic [16:0] stall_reg, stall_next;
    logic [2:0]  pending_reg, pending_next;

    // Sample and working registers
    logic [31:0] step_reg, step_next;
    logic [31:0] loss_reg, loss_next;
    logic [31:0] grad_reg, grad_next;
    logic [63:0] time_reg, time_next;
    logic [48:0] prod_reg, prod_next;
    logic [31:0] thr_g_reg, thr_g_next;
    logic [31:0] thr_l_reg, thr_l_next;
    logic [16:0] sev_g_reg, sev_g_next;
    logic [16:0] sev_l_reg, sev_l_next;

    // Shared units
    logic [16:0] mul_a;
    logic [31:0] mul_b;
    esp_pkg::div_req_t div_req;
    esp_pkg::div_rsp_t div_rsp;

    // Helpers
    logic        loss_up, grad_up;
    logic [31:0] loss_diff, grad_diff;
    logic [48:0] round_ema, round_thr;
    logic [31:0] ema_step, thr_sat;
    logic [31:0] sev_v, sev_t, sev_diff;
    logic        sev_fire, sev_full;
    logic        improve;
    logic [16:0] stall_inc;
    logic [16:0] win_plus;
    logic [17:0] gain_num;
    logic        cfg_fire, in_fire;

    esp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Distances from the averages and rounded multiplier results
    always_comb
    begin
        loss_up   = loss_reg >= la_reg;
        grad_up   = grad_reg >= ga_reg;
        loss_diff = loss_up ? loss_reg - la_reg : la_reg - loss_reg;
        grad_diff = grad_up ? grad_reg - ga_reg : ga_reg - grad_reg;
        round_ema = prod_reg + 49'd32768;
        ema_step  = round_ema[47:16];
        round_thr = prod_reg + 49'd128;
        thr_sat   = (|round_thr[48:40]) ? 32'hFFFF_FFFF : round_thr[39:8];
    end

    // Marker test and severity shortcut for the metric under check
    always_comb
    begin
        if (state_reg == esp_pkg::ST_SEV_L)
        begin
            sev_v    = loss_reg;
            sev_t    = thr_l_reg;
            sev_fire = (la_reg > esp_pkg::AVG_FLOOR) && (loss_reg > thr_l_reg);
        end
        else
        begin
            sev_v    = grad_reg;
            sev_t    = thr_g_reg;
            sev_fire = (ga_reg > esp_pkg::AVG_FLOOR) && (grad_reg > thr_g_reg);
        end
        sev_diff = sev_v - sev_t;
        sev_full = (sev_t == '0) || (sev_diff >= sev_t);
    end

    // Improvement test and stall counting
    always_comb
    begin
        improve   = ({1'b0, loss_reg} + esp_pkg::IMPROVE_MARGIN) <= {1'b0, best_reg};
        stall_inc = (stall_reg < esp_pkg::STALL_MAX) ? stall_reg + 17'd1 : stall_reg;
    end

    // Gain divisor and dividend from a window write
    always_comb
    begin
        win_plus = ((cfg_data == '0) ? 17'd1 : {1'b0, cfg_data}) + 17'd1;
        gain_num = esp_pkg::GAIN_NUM_BASE + {2'b00, win_plus[16:1]};
    end

    assign cfg_ready = (state_reg == esp_pkg::ST_IDLE);
    assign in_ready  = (state_reg == esp_pkg::ST_IDLE) && !cfg_valid;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign in_fire   = in_valid && in_ready;

    assign prod_next = 49'(mul_a) * 49'(mul_b);

    // Sequencer: next state, shared unit operands and register updates
    always_comb
    begin
        state_next   = state_reg;
        gain_next    = gain_reg;
        expl_next    = expl_reg;
        spike_next   = spike_reg;
        plat_next    = plat_reg;
        first_next   = first_reg;
        la_next      = la_reg;
        ga_next      = ga_reg;
        best_next    = best_reg;
        stall_next   = stall_reg;
        pending_next = pending_reg;
        step_next    = step_reg;
        loss_next    = loss_reg;
        grad_next    = grad_reg;
        time_next    = time_reg;
        thr_g_next   = thr_g_reg;
        thr_l_next   = thr_l_reg;
        sev_g_next   = sev_g_reg;
        sev_l_next   = sev_l_reg;
        mul_a        = gain_reg;
        mul_b        = loss_diff;

        div_req          = '0;
        div_req.divisor  = sev_t;
        div_req.rem_init = sev_diff;
        div_req.steps    = esp_pkg::SEV_STEPS;

        case (state_reg)
            esp_pkg::ST_IDLE:
            begin
                if (cfg_fire)
                begin
                    case (cfg_index)
                        esp_pkg::CFG_EMA_WINDOW:
                        begin
                            div_req.start    = 1'b1;
                            div_req.divisor  = {15'd0, win_plus};
                            div_req.rem_init = '0;
                            div_req.num      = gain_num;
                            div_req.steps    = esp_pkg::GAIN_STEPS;
                            state_next       = esp_pkg::ST_GAIN;
                        end
                        esp_pkg::CFG_EXPLOSION_FACTOR: expl_next  = cfg_data;
                        esp_pkg::CFG_SPIKE_FACTOR:     spike_next = cfg_data;
                        esp_pkg::CFG_PLATEAU_STEPS:    plat_next  = cfg_data;
                        default: ;
                    endcase
                end
                else if (in_fire)
                begin
                    step_next    = step_number;
                    loss_next    = loss_value;
                    grad_next    = grad_value;
                    time_next    = time_stamp;
                    pending_next = '0;
                    if (first_reg)
                    begin
                        // seed averages and best loss, no marker
                        la_next    = loss_value;
                        ga_next    = grad_value;
                        best_next  = loss_value;
                        first_next = 1'b0;
                    end
                    else
                    begin
                        state_next = esp_pkg::ST_MUL_LOSS;
                    end
                end
            end
            esp_pkg::ST_GAIN:
            begin
                if (div_rsp.done)
                begin
                    gain_next  = div_rsp.quot[16:0];
                    state_next = esp_pkg::ST_IDLE;
                end
            end
            esp_pkg::ST_MUL_LOSS:
            begin
                mul_a      = gain_reg;
                mul_b      = loss_diff;
                state_next = esp_pkg::ST_UPD_LOSS;
            end
            esp_pkg::ST_UPD_LOSS:
            begin
                la_next    = loss_up ? la_reg + ema_step : la_reg - ema_step;
                state_next = esp_pkg::ST_MUL_GRAD;
            end
            esp_pkg::ST_MUL_GRAD:
            begin
                mul_a      = gain_reg;
                mul_b      = grad_diff;
                state_next = esp_pkg::ST_UPD_GRAD;
            end
            esp_pkg::ST_UPD_GRAD:
            begin
                ga_next    = grad_up ? ga_reg + ema_step : ga_reg - ema_step;
                state_next = esp_pkg::ST_MUL_TG;
            end
            esp_pkg::ST_MUL_TG:
            begin
                mul_a      = {1'b0, expl_reg};
                mul_b      = ga_reg;
                state_next = esp_pkg::ST_THR_G;
            end
            esp_pkg::ST_THR_G:
            begin
                thr_g_next = thr_sat;
                state_next = esp_pkg::ST_SEV_G;
            end
            esp_pkg::ST_SEV_G:
            begin
                state_next = esp_pkg::ST_MUL_TL;
                if (sev_fire)
                begin
                    pending_next[0] = 1'b1;
                    if (sev_full)
                    begin
                        sev_g_next = esp_pkg::SEV_ONE;
                    end
                    else
                    begin
                        div_req.start = 1'b1;
                        state_next    = esp_pkg::ST_DIV_G;
                    end
                end
            end
            esp_pkg::ST_DIV_G:
            begin
                if (div_rsp.done)
                begin
                    sev_g_next = {1'b0, div_rsp.quot[15:0]};
                    state_next = esp_pkg::ST_MUL_TL;
                end
            end
            esp_pkg::ST_MUL_TL:
            begin
                mul_a      = {1'b0, spike_reg};
                mul_b      = la_reg;
                state_next = esp_pkg::ST_THR_L;
            end
            esp_pkg::ST_THR_L:
            begin
                thr_l_next = thr_sat;
                state_next = esp_pkg::ST_SEV_L;
            end
            esp_pkg::ST_SEV_L:
            begin
                state_next = esp_pkg::ST_STALL;
                if (sev_fire)
                begin
                    pending_next[1] = 1'b1;
                    if (sev_full)
                    begin
                        sev_l_next = esp_pkg::SEV_ONE;
                    end
                    else
                    begin
                        div_req.start = 1'b1;
                        state_next    = esp_pkg::ST_DIV_L;
                    end
                end
            end
            esp_pkg::ST_DIV_L:
            begin
                if (div_rsp.done)
                begin
                    sev_l_next = {1'b0, div_rsp.quot[15:0]};
                    state_next = esp_pkg::ST_STALL;
                end
            end
            esp_pkg::ST_STALL:
            begin
                // advance the stall count or restart it on a new best loss
                if (improve)
                begin
                    best_next  = loss_reg;
                    stall_next = '0;
                end
                else
                begin
                    stall_next = stall_inc;
                end
                pending_next[2] = (stall_next == {1'b0, plat_reg});
                state_next = (pending_next == '0) ? esp_pkg::ST_IDLE : esp_pkg::ST_OUT;
            end
            esp_pkg::ST_OUT:
            begin
                // drop the marker just taken, go idle after the last one
                if (out_ready)
                begin
                    pending_next = pending_reg & (pending_reg - 3'd1);
                    if (pending_next == '0)
                    begin
                        state_next = esp_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = esp_pkg::ST_IDLE;
            end
        endcase
    end

    // Control and detector state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= esp_pkg::ST_IDLE;
            gain_reg    <= esp_pkg::GAIN_RESET;
            expl_reg    <= esp_pkg::EXPLOSION_RST;
            spike_reg   <= esp_pkg::SPIKE_RST;
            plat_reg    <= esp_pkg::PLATEAU_RST;
            first_reg   <= 1'b1;
            la_reg      <= '0;
            ga_reg      <= '0;
            best_reg    <= '0;
            stall_reg   <= '0;
            pending_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            gain_reg    <= gain_next;
            expl_reg    <= expl_next;
            spike_reg   <= spike_next;
            plat_reg    <= plat_next;
            first_reg   <= first_next;
            la_reg      <= la_next;
            ga_reg      <= ga_next;
            best_reg    <= best_next;
            stall_reg   <= stall_next;
            pending_reg <= pending_next;
        end
    end

    // Sample and working registers
    always_ff @(posedge clk)
    begin
        step_reg  <= step_next;
        loss_reg  <= loss_next;
        grad_reg  <= grad_next;
        time_reg  <= time_next;
        prod_reg  <= prod_next;
        thr_g_reg <= thr_g_next;
        thr_l_reg <= thr_l_next;
        sev_g_reg <= sev_g_next;
        sev_l_reg <= sev_l_next;
    end

    // Present the lowest pending marker
    always_comb
    begin
        if (pending_reg[0])
        begin
            marker_kind      = esp_pkg::KIND_GRAD;
            marker_severity  = sev_g_reg;
            marker_value     = grad_reg;
            marker_threshold = thr_g_reg;
        end
        else if (pending_reg[1])
        begin
            marker_kind      = esp_pkg::KIND_LOSS;
            marker_severity  = sev_l_reg;
            marker_value     = loss_reg;
            marker_threshold = thr_l_reg;
        end
        else
        begin
            marker_kind      = esp_pkg::KIND_PLATEAU;
            marker_severity  = esp_pkg::SEV_HALF;
            marker_value     = loss_reg;
            marker_threshold = best_reg;
        end
    end

    assign out_valid   = (state_reg == esp_pkg::ST_OUT);
    assign marker_step = step_reg;
    assign marker_time = time_reg;
    assign marker_last = ((pending_reg & (pending_reg - 3'd1)) == 3'd0);

    // Markers are only offered while some marker is pending
    assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> pending_reg != '0)
        else $error("detector: marker offered with nothing pending");

    // A sample is never taken while markers are still going out
    assert property (@(posedge clk) disable iff (!rst_n) !(in_ready && out_valid))
        else $error("detector: input ready during marker output");

    // The gain never reaches zero, or the averages would freeze
    assert property (@(posedge clk) disable iff (!rst_n) gain_reg != '0)
        else $error("detector: zero smoothing gain");

    // A taken marker that is not the last leaves another one to send
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !marker_last) |=> out_valid)
        else $error("detector: marker lost after a non-final marker");

endmodule

FILE: dv/esp_marker_checker.sv
// ----------------------------------------------------------------------------
// esp_marker_checker: marker predictor and scoreboard for the detector
// Watches the register, sample and marker channels. Every accepted sample
// runs through a cycle-free model of the averages, thresholds and stall
// counter; the markers it predicts are queued and compared field by field
// against the markers the block hands out.
// ----------------------------------------------------------------------------
module esp_marker_checker (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data,

    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [31:0] step_number,
    input  logic [31:0] loss_value,
    input  logic [31:0] grad_value,
    input  logic [63:0] time_stamp,

    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [31:0] marker_step,
    input  logic [1:0]  marker_kind,
    input  logic [16:0] marker_severity,
    input  logic [31:0] marker_value,
    input  logic [31:0] marker_threshold,
    input  logic [63:0] marker_time,
    input  logic        marker_last,

    output int          fail_count,
    output int          pending_markers
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [31:0] step;
        logic [1:0]  kind;
        logic [16:0] sev;
        logic [31:0] val;
        logic [31:0] thr;
        logic [63:0] ts;
        logic        last;
    } marker_t;

    // Model copy of the registers
    logic [15:0] window_len;
    logic [15:0] grad_factor;
    logic [15:0] loss_factor;
    logic [15:0] plateau_limit;

    // Model copy of the tracking state
    logic        seed_pending;
    logic [31:0] loss_avg;
    logic [31:0] grad_avg;
    logic [31:0] best_loss;
    logic [16:0] stall_steps;
    logic [16:0] ema_gain;

    marker_t     expected_markers[$];
    int unsigned markers_seen;

    // Gain 2/(N+1) in Q1.16, rounded to nearest; a window of 0 acts as 1
    function automatic logic [16:0] window_gain(input logic [15:0] n);
        int unsigned d;
        int unsigned g;
        d = ((n == 16'd0) ? 32'd1 : {16'd0, n}) + 32'd1;
        g = (32'd131072 + d / 2) / d;
        return g[16:0];
    endfunction

    // Move an average toward a sample, rounding the step half away from zero
    function automatic logic [31:0] ema_advance(input logic [31:0] avg,
                                                input logic [31:0] x,
                                                input logic [16:0] g);
        logic [63:0] diff;
        logic [63:0] delta;
        if (x >= avg)
        begin
            diff  = {32'd0, x} - {32'd0, avg};
            delta = ({47'd0, g} * diff + 64'd32768) >> 16;
            return avg + delta[31:0];
        end
        diff  = {32'd0, avg} - {32'd0, x};
        delta = ({47'd0, g} * diff + 64'd32768) >> 16;
        return avg - delta[31:0];
    endfunction

    // Q8.8 factor times average, rounded and clipped to 32 bits
    function automatic logic [31:0] scaled_threshold(input logic [15:0] f,
                                                     input logic [31:0] avg);
        logic [63:0] p;
        p = ({48'd0, f} * {32'd0, avg} + 64'd128) >> 8;
        return (p > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : p[31:0];
    endfunction

    // Excess over threshold as a fraction of it, Q1.16, clipped at 1.0
    function automatic logic [16:0] excess_severity(input logic [31:0] v,
                                                    input logic [31:0] thr);
        logic [63:0] q;
        if (thr == 32'd0)
            return esp_pkg::SEV_ONE;
        q = (({32'd0, v} - {32'd0, thr}) << 16) / {32'd0, thr};
        return (q > {47'd0, esp_pkg::SEV_ONE}) ? esp_pkg::SEV_ONE : q[16:0];
    endfunction

    task automatic report_mismatch(input string what);
        fail_count++;
        $display("%0t ns mismatch: %s", $time, what);
    endtask

    task automatic apply_register(input logic [7:0] idx, input logic [15:0] data);
        case (idx)
            esp_pkg::CFG_EMA_WINDOW:
            begin
                window_len = data;
                ema_gain   = window_gain(data);
            end
            esp_pkg::CFG_EXPLOSION_FACTOR: grad_factor   = data;
            esp_pkg::CFG_SPIKE_FACTOR:     loss_factor   = data;
            esp_pkg::CFG_PLATEAU_STEPS:    plateau_limit = data;
            default: ;  // ignore writes past the register list
        endcase
    endtask

    // Run one sample request through the model and queue its markers
    task automatic predict_markers(input logic [31:0] stp, input logic [31:0] loss,
                                   input logic [31:0] grad, input logic [63:0] ts);
        marker_t     found[$];
        marker_t     m;
        logic [31:0] thr;
        found.delete();
        if (seed_pending)
        begin
            loss_avg     = loss;
            grad_avg     = grad;
            best_loss    = loss;
            seed_pending = 1'b0;
            return;
        end
        loss_avg = ema_advance(loss_avg, loss, ema_gain);
        grad_avg = ema_advance(grad_avg, grad, ema_gain);
        m.step = stp;
        m.ts   = ts;
        m.last = 1'b0;

        // Gradient explosion
        thr = scaled_threshold(grad_factor, grad_avg);
        if (grad_avg > esp_pkg::AVG_FLOOR && grad > thr)
        begin
            m.kind = esp_pkg::KIND_GRAD;
            m.sev  = excess_severity(grad, thr);
            m.val  = grad;
            m.thr  = thr;
            found.insert(found.size(), m);
        end

        // Loss spike
        thr = scaled_threshold(loss_factor, loss_avg);
        if (loss_avg > esp_pkg::AVG_FLOOR && loss > thr)
        begin
            m.kind = esp_pkg::KIND_LOSS;
            m.sev  = excess_severity(loss, thr);
            m.val  = loss;
            m.thr  = thr;
            found.insert(found.size(), m);
        end

        // Track improvement, hold the stall count once it saturates
        if ({1'b0, loss} + esp_pkg::IMPROVE_MARGIN <= {1'b0, best_loss})
        begin
            best_loss   = loss;
            stall_steps = '0;
        end
        else if (stall_steps < esp_pkg::STALL_MAX)
            stall_steps = stall_steps + 17'd1;

        // Loss plateau
        if (stall_steps == {1'b0, plateau_limit})
        begin
            m.kind = esp_pkg::KIND_PLATEAU;
            m.sev  = esp_pkg::SEV_HALF;
            m.val  = loss;
            m.thr  = best_loss;
            found.insert(found.size(), m);
        end

        if (found.size() > 0)
            found[found.size() - 1].last = 1'b1;
        foreach (found[i])
            expected_markers.insert(expected_markers.size(), found[i]);
    endtask

    task automatic compare_marker();
        marker_t want;
        markers_seen++;
        if (expected_markers.size() == 0)
        begin
            report_mismatch($sformatf("marker %0d arrived with none pending (step %h)",
                                      markers_seen, marker_step));
            return;
        end
        want = expected_markers.pop_front();
        if (marker_step !== want.step)
            report_mismatch($sformatf("marker %0d step %h, want %h",
                                      markers_seen, marker_step, want.step));
        if (marker_kind !== want.kind)
            report_mismatch($sformatf("marker %0d kind %0d, want %0d",
                                      markers_seen, marker_kind, want.kind));
        if (marker_severity !== want.sev)
            report_mismatch($sformatf("marker %0d severity %0d, want %0d",
                                      markers_seen, marker_severity, want.sev));
        if (marker_value !== want.val)
            report_mismatch($sformatf("marker %0d value %h, want %h",
                                      markers_seen, marker_value, want.val));
        if (marker_threshold !== want.thr)
            report_mismatch($sformatf("marker %0d threshold %h, want %h",
                                      markers_seen, marker_threshold, want.thr));
        if (marker_time !== want.ts)
            report_mismatch($sformatf("marker %0d time %h, want %h",
                                      markers_seen, marker_time, want.ts));
        if (marker_last !== want.last)
            report_mismatch($sformatf("marker %0d last %b, want %b",
                                      markers_seen, marker_last, want.last));
    endtask

    // Watch all three channels on the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_len      = 16'd20;
            grad_factor     = esp_pkg::EXPLOSION_RST;
            loss_factor     = esp_pkg::SPIKE_RST;
            plateau_limit   = esp_pkg::PLATEAU_RST;
            ema_gain        = window_gain(16'd20);
            seed_pending    = 1'b1;
            loss_avg        = '0;
            grad_avg        = '0;
            best_loss       = '0;
            stall_steps     = '0;
            markers_seen    = 0;
            fail_count      = 0;
            expected_markers.delete();
            pending_markers = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                apply_register(cfg_index, cfg_data);
            if (in_valid && in_ready)
                predict_markers(step_number, loss_value, grad_value, time_stamp);
            if (out_valid && out_ready)
                compare_marker();
            pending_markers = expected_markers.size();
        end
    end

endmodule

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the EMA spike and plateau detector
// Drives register writes and metric samples, with random bursts of idle
// cycles on the sample and marker channels. A directed opening hits the
// field extremes and the corner cases, random phases under several register
// settings follow, and a stall run closes that raises the plateau marker
// once and then holds. Checking lives in the marker checker beside the block.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SETTLE_CYCLES = 60;

    logic        clk = 1'b0;
    logic        rst_n;

    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_index;
    logic [15:0] cfg_data;

    logic        in_valid;
    logic        in_ready;
    logic [31:0] step_number;
    logic [31:0] loss_value;
    logic [31:0] grad_value;
    logic [63:0] time_stamp;

    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] marker_step;
    logic [1:0]  marker_kind;
    logic [16:0] marker_severity;
    logic [31:0] marker_value;
    logic [31:0] marker_threshold;
    logic [63:0] marker_time;
    logic        marker_last;

    int          fail_count;
    int          pending_markers;

    logic        idle_on = 1'b0;
    int          sink_hold = 0;

    int unsigned step_ctr;
    logic [63:0] ts_ctr;
    logic [31:0] base_loss;
    logic [31:0] base_grad;
    logic [31:0] walk_loss;

    always #6 clk = ~clk;

    ema_spike_plateau_detector DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .step_number      (step_number),
        .loss_value       (loss_value),
        .grad_value       (grad_value),
        .time_stamp       (time_stamp),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .marker_step      (marker_step),
        .marker_kind      (marker_kind),
        .marker_severity  (marker_severity),
        .marker_value     (marker_value),
        .marker_threshold (marker_threshold),
        .marker_time      (marker_time),
        .marker_last      (marker_last)
    );

    esp_marker_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .step_number      (step_number),
        .loss_value       (loss_value),
        .grad_value       (grad_value),
        .time_stamp       (time_stamp),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .marker_step      (marker_step),
        .marker_kind      (marker_kind),
        .marker_severity  (marker_severity),
        .marker_value     (marker_value),
        .marker_threshold (marker_threshold),
        .marker_time      (marker_time),
        .marker_last      (marker_last),
        .fail_count       (fail_count),
        .pending_markers  (pending_markers)
    );

    // Stall the marker consumer in random bursts while idling is on
    always @(negedge clk)
    begin
        if (sink_hold > 0)
        begin
            sink_hold = sink_hold - 1;
            out_ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            sink_hold = $urandom_range(0, 16);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    function automatic logic [31:0] sat32(input logic [63:0] x);
        return (x > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : x[31:0];
    endfunction

    // Jitter a level by about plus or minus six percent
    function automatic logic [31:0] near_level(input logic [31:0] x);
        logic [63:0] v;
        v = {32'd0, x} - {32'd0, x} / 16 + ({32'd0, $urandom} % ({32'd0, x} / 8 + 1));
        return sat32(v);
    endfunction

    function automatic logic [31:0] spike_of(input logic [31:0] x);
        return sat32({32'd0, x} * $urandom_range(2, 40));
    endfunction

    function automatic logic [31:0] fresh_level();
        return ($urandom >> $urandom_range(4, 20)) + 32'd1000;
    endfunction

    // Present one sample request and hold it until accepted
    task automatic send_sample(input logic [31:0] stp, input logic [31:0] loss,
                               input logic [31:0] grad, input logic [63:0] ts);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        in_valid    <= 1'b1;
        step_number <= stp;
        loss_value  <= loss;
        grad_value  <= grad;
        time_stamp  <= ts;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Hold a register write request until accepted; caller drops valid
    task automatic write_reg(input esp_pkg::cfg_idx_t idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Drain pending markers and let a silent sample finish
    task automatic wait_quiet();
        in_valid <= 1'b0;
        while (pending_markers != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic load_setting(input logic [15:0] win, input logic [15:0] grad_f,
                                input logic [15:0] loss_f, input logic [15:0] limit);
        wait_quiet();
        write_reg(esp_pkg::CFG_EMA_WINDOW, win);
        write_reg(esp_pkg::CFG_EXPLOSION_FACTOR, grad_f);
        write_reg(esp_pkg::CFG_SPIKE_FACTOR, loss_f);
        write_reg(esp_pkg::CFG_PLATEAU_STEPS, limit);
        cfg_valid <= 1'b0;
    endtask

    // Mostly steady metrics with spikes and descents, some pure noise
    task automatic send_random_item();
        logic [31:0] s;
        logic [31:0] l;
        logic [31:0] g;
        logic [63:0] t;
        int unsigned r;
        r        = $urandom_range(0, 99);
        step_ctr = step_ctr + 1;
        ts_ctr   = ts_ctr + $urandom_range(1, 1000000);
        s        = step_ctr;
        t        = ts_ctr;
        l        = near_level(base_loss);
        g        = near_level(base_grad);
        if (r < 10)
            g = spike_of(base_grad);
        else if (r < 20)
            l = spike_of(base_loss);
        else if (r < 24)
        begin
            l = spike_of(base_loss);
            g = spike_of(base_grad);
        end
        else if (r < 26)
        begin
            l = '1;
            g = '1;
        end
        else if (r < 34)
        begin
            s = $urandom;
            l = $urandom;
            g = $urandom;
            t = {$urandom, $urandom};
        end
        else if (r < 52)
        begin
            if (walk_loss < 32'd64)
                walk_loss = base_loss;
            walk_loss = walk_loss - walk_loss / 32 - 32'd8;
            l = walk_loss;
        end
        if ($urandom_range(0, 49) == 0)
        begin
            base_loss = fresh_level();
            base_grad = fresh_level();
            walk_loss = base_loss;
        end
        send_sample(s, l, g, t);
    endtask

    initial
    begin
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        step_number = '0;
        loss_value  = '0;
        grad_value  = '0;
        time_stamp  = '0;
        step_ctr    = 100;
        ts_ctr      = 64'd5000;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Seed, then explosion, spike, both with severity below full
        send_sample(32'd0, 32'h0001_0000, 32'h0000_8000, 64'd0);
        send_sample(32'd1, 32'h0001_0000, 32'h0000_8000, 64'd1000);
        send_sample(32'd2, 32'h0001_0000, 32'h0010_0000, 64'd2000);
        send_sample(32'd3, 32'h000A_0000, 32'h0000_8000, 64'd3000);
        send_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_sample(32'd0, 32'h0000_0800, 32'd0, 64'd0);

        // Zero thresholds with a short plateau limit: three markers at once
        load_setting(16'd20, 16'd0, 16'd0, 16'd2);
        repeat (4)
        begin
            step_ctr = step_ctr + 1;
            send_sample(step_ctr, 32'h0000_8000, 32'h0001_0000, {32'd0, step_ctr});
        end

        // Zero plateau limit fires on every improving sample
        load_setting(16'd20, 16'd1280, 16'd768, 16'd0);
        send_sample(32'd200, 32'h0000_0400, 32'h0000_8000, 64'd200);
        send_sample(32'd201, 32'h0000_0200, 32'h0000_8000, 64'd201);
        send_sample(32'd202, 32'h0000_0100, 32'h0000_8000, 64'd202);

        // Writes past the register list, then a window of zero
        wait_quiet();
        write_reg(esp_pkg::cfg_idx_t'(8'd4), 16'hFFFF);
        write_reg(esp_pkg::cfg_idx_t'(8'hFF), 16'hFFFF);
        write_reg(esp_pkg::CFG_EMA_WINDOW, 16'd0);
        cfg_valid <= 1'b0;
        send_sample(32'd300, 32'h0002_0000, 32'h0003_0000, 64'd300);
        send_sample(32'd301, 32'h0009_0000, 32'h0000_1000, 64'd301);

        // Random phases over several register settings
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:       load_setting(16'd0, 16'd256, 16'd0, 16'd1);
                1:       load_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                2:       load_setting(16'd3, 16'd512, 16'd384, 16'd4);
                default: load_setting(16'($urandom_range(1, 64)),
                                      16'($urandom_range(256, 1536)),
                                      16'($urandom_range(256, 1536)),
                                      16'($urandom_range(1, 12)));
            endcase
            idle_on   <= ($urandom_range(0, 3) != 0);
            base_loss = fresh_level();
            base_grad = fresh_level();
            walk_loss = base_loss;
            repeat (40) send_random_item();
        end

        // Stall run with no idling: restart the count, fire once, then hold
        load_setting(16'd0, 16'd256, 16'd256, 16'd24);
        idle_on <= 1'b0;
        step_ctr = step_ctr + 1;
        ts_ctr   = ts_ctr + 64'd1;
        send_sample(step_ctr, 32'd0, 32'h0001_0000, ts_ctr);
        repeat (40)
        begin
            step_ctr = step_ctr + 1;
            ts_ctr   = ts_ctr + 64'd1;
            send_sample(step_ctr, 32'hFFFF_0000, 32'h0001_0000, ts_ctr);
        end

        wait_quiet();
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Watchdog
    initial
    begin
        #4_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
